/* hw/rtl/etc1_pkg.sv */
// ----------------------------------------------------------------------------
// etc1_pkg
// shared types, modifier table and small arithmetic helpers for the encoder
// ----------------------------------------------------------------------------
`default_nettype none

package etc1_pkg;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    localparam int unsigned NUM_PIX = 16;
    localparam int unsigned ERR_W   = 18;   // one pixel, three channels
    localparam int unsigned SUB_W   = 21;   // eight pixels
    localparam int unsigned TOT_W   = 23;   // sixteen pixels plus headroom

    // modifier magnitude, hi selects the large column
    function automatic logic [7:0] mod_val(input logic [2:0] t, input logic hi);
        logic [7:0] v;
        case (t)
            3'd0:    v = hi ? 8'd8   : 8'd2;
            3'd1:    v = hi ? 8'd17  : 8'd5;
            3'd2:    v = hi ? 8'd29  : 8'd9;
            3'd3:    v = hi ? 8'd42  : 8'd13;
            3'd4:    v = hi ? 8'd60  : 8'd18;
            3'd5:    v = hi ? 8'd80  : 8'd24;
            3'd6:    v = hi ? 8'd106 : 8'd33;
            3'd7:    v = hi ? 8'd183 : 8'd47;
            default: v = 8'd0;
        endcase
        return v;
    endfunction

    // x / 255 for x below 65280
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] y;
        logic [16:0] z;
        y = {1'b0, x} + 17'd1;
        z = y + (y >> 8);
        return z[15:8];
    endfunction

    function automatic logic [7:0] ch_of(input t_rgb c, input logic [1:0] k);
        logic [7:0] v;
        case (k)
            2'd0:    v = c.red;
            2'd1:    v = c.green;
            default: v = c.blue;
        endcase
        return v;
    endfunction

    // subblock of pixel p (column-major) for a flip setting
    function automatic logic sub_of(input logic flip, input logic [3:0] p);
        return flip ? p[1] : p[3];
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/etc1_ifs.sv */
// ----------------------------------------------------------------------------
// etc1 channel interfaces
// pixel input channel and encoded block output channel, valid/ready
// ----------------------------------------------------------------------------
`default_nettype none

interface etc1_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface etc1_blk_if;
    logic        valid;
    logic        ready;
    logic [31:0] color_word;
    logic [31:0] index_word;
    modport source (output valid, output color_word, output index_word, input ready);
    modport sink   (input valid, input color_word, input index_word, output ready);
endinterface

`default_nettype wire

/* hw/rtl/etc1_block_encoder_top.sv */
// sequence: 16 pixel transfers, then sum, base and check, where a uniform block ends;
//   else per flip sum, base, check, deviation, per subblock (setup, search and table end
//   per table, subblock end) and flip end; the search runs one modifier per cycle
//   through the shared error unit (8 pixels a table, 2..3 tables)
// pixels of the next block are taken while a finished block waits at the output
// reset: synchronous active low, clears pixel count, sequencer and output valid
// ----------------------------------------------------------------------------
// etc1_block_encoder_top
// collects a 4x4 rgb block and encodes it as a 64-bit etc1 block
// ----------------------------------------------------------------------------
`default_nettype none

module etc1_block_encoder_top
    import etc1_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    etc1_pix_if.sink    i_pix,
    etc1_blk_if.source  o_blk
);

    typedef enum logic [3:0] {
        S_LOAD, S_SUM, S_BASE, S_CHK, S_DEV, S_TSET, S_SRCH, S_TEND, S_SEND, S_FEND
    } t_state;

    t_state            r_state;
    logic [3:0]        r_cnt;
    t_rgb              r_pix   [NUM_PIX];
    logic              r_flip;
    logic [3:0]        r_j;
    logic              r_s;
    logic [1:0]        r_m;
    logic [2:0]        r_t;
    logic [2:0]        r_tend;
    logic [10:0]       r_sum   [2][3];
    logic              r_same;
    logic [4:0]        r_b5    [2][3];
    logic [3:0]        r_q4    [2][3];
    logic              r_diff;
    logic [7:0]        r_maxdev[2];
    logic [2:0]        r_tsel  [2];
    logic [ERR_W-1:0]  r_be;
    logic [1:0]        r_bi;
    logic [SUB_W-1:0]  r_esum;
    logic [SUB_W-1:0]  r_bsub;
    logic [TOT_W-1:0]  r_total;
    logic [TOT_W-1:0]  r_best;
    logic [1:0]        r_cur   [NUM_PIX];
    logic [1:0]        r_bsel  [NUM_PIX];
    logic [31:0]       r_cw;
    logic [31:0]       r_iw;
    logic              r_ovalid;

    logic              in_xfer;
    logic [3:0]        sp;
    logic [3:0]        rd_idx;
    t_rgb              rd_pix;
    logic              rd_sub;
    t_rgb              base_c  [2];
    logic [7:0]        avg_c   [2][3];
    logic [4:0]        b5_c    [2][3];
    logic [3:0]        q4_c    [2][3];
    logic              diff_c;
    logic signed [5:0] dd;
    logic [7:0]        dev_max;
    logic [7:0]        dev_k;
    logic [2:0]        tp;
    logic [2:0]        tlo;
    logic [2:0]        thi;
    logic [ERR_W-1:0]  err;
    logic              lt;
    logic [ERR_W-1:0]  fin_e;
    logic [1:0]        fin_i;
    logic [31:0]       cw_c;
    logic [31:0]       iw_c;
    logic [4:0]        dq;

    assign in_xfer     = i_pix.valid && i_pix.ready;
    assign i_pix.ready = (r_state == S_LOAD) && !((r_cnt == 4'd15) && r_ovalid);

    assign o_blk.valid      = r_ovalid;
    assign o_blk.color_word = r_cw;
    assign o_blk.index_word = r_iw;

    // search pixel: j-th pixel of subblock s
    assign sp     = r_flip ? {r_j[2:1], r_s, r_j[0]} : {r_s, r_j[2:0]};
    assign rd_idx = (r_state == S_SRCH) ? sp : r_j;
    assign rd_pix = r_pix[rd_idx];
    assign rd_sub = sub_of(r_flip, rd_idx);

    always_comb begin
        for (int s = 0; s < 2; s++) begin
            base_c[s].red   = r_diff ? {r_b5[s][0], r_b5[s][0][4:2]} : {r_q4[s][0], r_q4[s][0]};
            base_c[s].green = r_diff ? {r_b5[s][1], r_b5[s][1][4:2]} : {r_q4[s][1], r_q4[s][1]};
            base_c[s].blue  = r_diff ? {r_b5[s][2], r_b5[s][2][4:2]} : {r_q4[s][2], r_q4[s][2]};
        end
    end

    // averages and quantization
    always_comb begin
        diff_c = 1'b1;
        dd     = '0;
        for (int s = 0; s < 2; s++) begin
            for (int k = 0; k < 3; k++) begin
                avg_c[s][k] = 8'((12'(r_sum[s][k]) + 12'd4) >> 3);
                b5_c[s][k]  = 5'(div255(16'(({8'd0, avg_c[s][k]} << 5) - {8'd0, avg_c[s][k]})
                                        + 16'd127));
                q4_c[s][k]  = 4'(div255(16'(({8'd0, avg_c[s][k]} << 4) - {8'd0, avg_c[s][k]})
                                        + 16'd127));
            end
        end
        for (int k = 0; k < 3; k++) begin
            dd = $signed({1'b0, b5_c[1][k]}) - $signed({1'b0, b5_c[0][k]});
            if (dd < -6'sd4 || dd > 6'sd3)
                diff_c = 1'b0;
        end
    end

    // running largest channel deviation of the subblock from its base, taking in the current pixel
    always_comb begin
        dev_max = r_maxdev[rd_sub];
        dev_k   = '0;
        for (int k = 0; k < 3; k++) begin
            dev_k = (ch_of(rd_pix, 2'(k)) >= ch_of(base_c[rd_sub], 2'(k)))
                  ? ch_of(rd_pix, 2'(k)) - ch_of(base_c[rd_sub], 2'(k))
                  : ch_of(base_c[rd_sub], 2'(k)) - ch_of(rd_pix, 2'(k));
            if (dev_k > dev_max)
                dev_max = dev_k;
        end
    end

    // table preselection: lowest table whose large modifier covers the deviation
    always_comb begin
        tp = 3'd7;
        for (int t = 7; t >= 0; t--) begin
            if (mod_val(3'(t), 1'b1) >= r_maxdev[r_s])
                tp = 3'(t);
        end
        tlo = (tp == 3'd0) ? 3'd0 : tp - 3'd1;
        thi = (tp == 3'd7) ? 3'd7 : tp + 3'd1;
    end

    etc1_err_unit u_err (
        .i_pix  (rd_pix),
        .i_base (base_c[r_s]),
        .i_mag  (mod_val(r_t, r_m[0])),
        .i_neg  (r_m[1]),
        .o_err  (err)
    );

    assign lt    = err < r_be;
    assign fin_e = lt ? err : r_be;
    assign fin_i = lt ? r_m : r_bi;

    always_comb begin
        cw_c = '0;
        dq   = '0;
        for (int k = 0; k < 3; k++) begin
            dq = r_b5[1][k] - r_b5[0][k];
            cw_c[31-8*k -: 8] = r_diff ? {r_b5[0][k], dq[2:0]} : {r_q4[0][k], r_q4[1][k]};
        end
        cw_c[7:0] = {r_tsel[0], r_tsel[1], r_diff, r_flip};
        for (int p = 0; p < NUM_PIX; p++) begin
            iw_c[16+p] = r_bsel[p][1];
            iw_c[p]    = r_bsel[p][0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && o_blk.ready)
                r_ovalid <= 1'b0;
            case (r_state)
                S_LOAD: begin
                    if (in_xfer) begin
                        r_pix[r_cnt] <= '{red: i_pix.red, green: i_pix.green, blue: i_pix.blue};
                        r_cnt        <= r_cnt + 4'd1;
                        if (r_cnt == 4'd15) begin
                            r_state <= S_SUM;
                            r_flip  <= 1'b0;
                            r_j     <= '0;
                            r_same  <= 1'b1;
                            r_best  <= '1;
                            for (int s = 0; s < 2; s++)
                                for (int k = 0; k < 3; k++)
                                    r_sum[s][k] <= '0;
                        end
                    end
                end
                S_SUM: begin
                    for (int k = 0; k < 3; k++)
                        r_sum[rd_sub][k] <= r_sum[rd_sub][k] + {3'd0, ch_of(rd_pix, 2'(k))};
                    if (!r_flip && (rd_pix != r_pix[0]))
                        r_same <= 1'b0;
                    r_j <= r_j + 4'd1;
                    if (r_j == 4'd15)
                        r_state <= S_BASE;
                end
                S_BASE: begin
                    r_b5    <= b5_c;
                    r_q4    <= q4_c;
                    r_diff  <= diff_c;
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    if (r_same && !r_flip) begin
                        // uniform block: first base, zero delta, tables and indices zero
                        r_cw     <= {r_b5[0][0], 3'd0, r_b5[0][1], 3'd0, r_b5[0][2], 3'd0,
                                     8'h02};
                        r_iw     <= '0;
                        r_ovalid <= 1'b1;
                        r_state  <= S_LOAD;
                    end else begin
                        r_j         <= '0;
                        r_maxdev[0] <= '0;
                        r_maxdev[1] <= '0;
                        r_state     <= S_DEV;
                    end
                end
                S_DEV: begin
                    r_maxdev[rd_sub] <= dev_max;
                    r_j              <= r_j + 4'd1;
                    if (r_j == 4'd15) begin
                        r_s     <= 1'b0;
                        r_total <= '0;
                        r_state <= S_TSET;
                    end
                end
                S_TSET: begin
                    r_t     <= tlo;
                    r_tend  <= thi;
                    r_bsub  <= '1;
                    r_esum  <= '0;
                    r_j     <= '0;
                    r_m     <= '0;
                    r_state <= S_SRCH;
                end
                S_SRCH: begin
                    if (r_m != 2'd3) begin
                        if (r_m == 2'd0 || lt) begin
                            r_be <= err;
                            r_bi <= r_m;
                        end
                        r_m <= r_m + 2'd1;
                    end else begin
                        r_esum  <= r_esum + SUB_W'(fin_e);
                        r_cur[sp] <= fin_i;
                        r_m     <= '0;
                        r_j     <= {1'b0, r_j[2:0] + 3'd1};
                        if (r_j[2:0] == 3'd7)
                            r_state <= S_TEND;
                    end
                end
                S_TEND: begin
                    if (r_esum < r_bsub) begin
                        r_bsub       <= r_esum;
                        r_tsel[r_s]  <= r_t;
                        for (int p = 0; p < NUM_PIX; p++)
                            if (sub_of(r_flip, 4'(p)) == r_s)
                                r_bsel[p] <= r_cur[p];
                    end
                    r_esum <= '0;
                    r_j    <= '0;
                    if (r_t == r_tend) begin
                        r_state <= S_SEND;
                    end else begin
                        r_t     <= r_t + 3'd1;
                        r_state <= S_SRCH;
                    end
                end
                S_SEND: begin
                    r_total <= r_total + TOT_W'(r_bsub);
                    if (!r_s) begin
                        r_s     <= 1'b1;
                        r_state <= S_TSET;
                    end else begin
                        r_state <= S_FEND;
                    end
                end
                S_FEND: begin
                    if (r_total < r_best) begin
                        r_best <= r_total;
                        r_cw   <= cw_c;
                        r_iw   <= iw_c;
                    end
                    if (!r_flip) begin
                        r_flip  <= 1'b1;
                        r_j     <= '0;
                        for (int s = 0; s < 2; s++)
                            for (int k = 0; k < 3; k++)
                                r_sum[s][k] <= '0;
                        r_state <= S_SUM;
                    end else begin
                        r_ovalid <= 1'b1;
                        r_state  <= S_LOAD;
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_LOAD) |-> !i_pix.ready)
        else $error("pixel accepted while encoding");

    a_cnt_on_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && !in_xfer) |=> $stable(r_cnt))
        else $error("pixel count moved without a transfer");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && (r_cnt == 4'd15)) |-> !i_pix.ready)
        else $error("block completed while output still pending");

    a_search_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SRCH) |-> (r_t <= r_tend))
        else $error("table search ran past its range");
`endif

endmodule

`default_nettype wire

/* hw/rtl/etc1_err_unit.sv */
// ----------------------------------------------------------------------------
// etc1_err_unit
// squared error of one pixel against a base color shifted by one modifier
// ----------------------------------------------------------------------------
`default_nettype none

module etc1_err_unit
    import etc1_pkg::*;
(
    input  wire t_rgb             i_pix,
    input  wire t_rgb             i_base,
    input  wire logic [7:0]       i_mag,
    input  wire logic             i_neg,
    output logic [ERR_W-1:0]      o_err
);

    logic signed [9:0]  shifted [3];
    logic        [7:0]  clamped [3];
    logic signed [8:0]  dlt     [3];
    logic        [15:0] sq      [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            shifted[k] = i_neg ? $signed({2'b00, ch_of(i_base, 2'(k))}) - $signed({2'b00, i_mag})
                               : $signed({2'b00, ch_of(i_base, 2'(k))}) + $signed({2'b00, i_mag});
            if (shifted[k] < 0)
                clamped[k] = 8'd0;
            else if (shifted[k] > 10'sd255)
                clamped[k] = 8'd255;
            else
                clamped[k] = shifted[k][7:0];
            dlt[k] = $signed({1'b0, ch_of(i_pix, 2'(k))}) - $signed({1'b0, clamped[k]});
            sq[k]  = 16'(dlt[k] * dlt[k]);
        end
        o_err = ERR_W'(sq[0]) + ERR_W'(sq[1]) + ERR_W'(sq[2]);
    end

endmodule

`default_nettype wire

/* tb/tb_etc1_block_encoder_top.sv */
// ----------------------------------------------------------------------------
// tb_etc1_block_encoder_top
// streams 4x4 rgb blocks into the etc1 encoder and checks every encoded block
// against a behavioral encoder, under random stalls on both channels
// ----------------------------------------------------------------------------
`default_nettype none

module tb_etc1_block_encoder_top;
    import etc1_pkg::*;

    typedef struct {
        logic [31:0] color_word;
        logic [31:0] index_word;
        logic        known;
    } t_blk;

    typedef struct {
        t_rgb        pix;
        logic [31:0] color_word;
        logic [31:0] index_word;
        logic        known;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    etc1_pix_if i_pix ();
    etc1_blk_if o_blk ();

    etc1_block_encoder_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (i_pix),
        .o_blk   (o_blk)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    t_rgb        block_pix [16];
    int          pix_slot;
    t_blk        blk_expected [$];
    int          err_count;
    int          blk_checked;
    int          pix_sent;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          recv_hold_cycles;
    t_row        pix_table [$];

    function automatic int clamp8(input int v);
        return v < 0 ? 0 : (v > 255 ? 255 : v);
    endfunction

    function automatic int quant5(input int c);
        return (c * 31 + 127) / 255;
    endfunction

    function automatic int mod_mag(input int t, input int hi);
        int tab [8][2];
        tab = '{'{2, 8}, '{5, 17}, '{9, 29}, '{13, 42}, '{18, 60}, '{24, 80},
                '{33, 106}, '{47, 183}};
        return tab[t][hi];
    endfunction

    function automatic int chan(input t_rgb c, input int k);
        return k == 0 ? int'(c.red) : (k == 1 ? int'(c.green) : int'(c.blue));
    endfunction

    function automatic int half_of(input int flip, input int p);
        return flip ? ((p & 3) >> 1) : (p >> 3);
    endfunction

    // encodes the sixteen stored pixels the way the block should
    function automatic t_blk encode_block();
        t_blk r;
        int  lowest_err, total, flip, s, k, p, t, m, tp, tlo, thi, maxdev, d, e, be, bi;
        int  esum, sub_err_min, best_t, md;
        int  avg [2][3];
        int  b5 [2][3];
        int  base [2][3];
        int  tsel [2];
        int  sel [16];
        int  cur [16];
        int  best_sel [16];
        logic        diff, same;
        logic [31:0] c, msb, lsb, byte_v;
        r.known = 1'b1;
        same = 1'b1;
        for (p = 1; p < 16; p++)
            if (block_pix[p] != block_pix[0]) same = 1'b0;
        if (same) begin
            r.color_word = (32'(quant5(block_pix[0].red)) << 27)
                         | (32'(quant5(block_pix[0].green)) << 19)
                         | (32'(quant5(block_pix[0].blue)) << 11) | 32'd2;
            r.index_word = '0;
            return r;
        end
        lowest_err = 32'h7fffffff;
        r.color_word = '0;
        r.index_word = '0;
        for (flip = 0; flip < 2; flip++) begin
            for (s = 0; s < 2; s++)
                for (k = 0; k < 3; k++) avg[s][k] = 0;
            for (p = 0; p < 16; p++)
                for (k = 0; k < 3; k++) avg[half_of(flip, p)][k] += chan(block_pix[p], k);
            for (s = 0; s < 2; s++)
                for (k = 0; k < 3; k++) avg[s][k] = (avg[s][k] + 4) / 8;
            diff = 1'b1;
            for (k = 0; k < 3; k++) begin
                b5[0][k] = quant5(avg[0][k]);
                b5[1][k] = quant5(avg[1][k]);
                d = b5[1][k] - b5[0][k];
                if (d < -4 || d > 3) diff = 1'b0;
            end
            for (s = 0; s < 2; s++)
                for (k = 0; k < 3; k++) begin
                    if (diff) begin
                        base[s][k] = (b5[s][k] << 3) | (b5[s][k] >> 2);
                    end else begin
                        d = (avg[s][k] * 15 + 127) / 255;
                        base[s][k] = (d << 4) | d;
                    end
                end
            total = 0;
            for (p = 0; p < 16; p++) sel[p] = 0;
            for (s = 0; s < 2; s++) begin
                maxdev = 0;
                for (p = 0; p < 16; p++) begin
                    if (half_of(flip, p) != s) continue;
                    for (k = 0; k < 3; k++) begin
                        d = chan(block_pix[p], k) - base[s][k];
                        if (d < 0) d = -d;
                        if (d > maxdev) maxdev = d;
                    end
                end
                tp = 7;
                for (t = 7; t >= 0; t--)
                    if (mod_mag(t, 1) >= maxdev) tp = t;
                tlo = tp > 0 ? tp - 1 : 0;
                thi = tp < 7 ? tp + 1 : 7;
                sub_err_min = 32'h7fffffff;
                best_t = tlo;
                for (p = 0; p < 16; p++) best_sel[p] = 0;
                for (t = tlo; t <= thi; t++) begin
                    esum = 0;
                    for (p = 0; p < 16; p++) cur[p] = 0;
                    for (p = 0; p < 16; p++) begin
                        if (half_of(flip, p) != s) continue;
                        be = 32'h7fffffff;
                        bi = 0;
                        for (m = 0; m < 4; m++) begin
                            md = mod_mag(t, m & 1);
                            if (m & 2) md = -md;
                            e = 0;
                            for (k = 0; k < 3; k++) begin
                                d = chan(block_pix[p], k) - clamp8(base[s][k] + md);
                                e += d * d;
                            end
                            if (e < be) begin
                                be = e;
                                bi = m;
                            end
                        end
                        esum += be;
                        cur[p] = bi;
                    end
                    if (esum < sub_err_min) begin
                        sub_err_min = esum;
                        best_t = t;
                        best_sel = cur;
                    end
                end
                tsel[s] = best_t;
                total += sub_err_min;
                for (p = 0; p < 16; p++)
                    if (half_of(flip, p) == s) sel[p] = best_sel[p];
            end
            if (total < lowest_err) begin
                lowest_err = total;
                c = '0;
                for (k = 0; k < 3; k++) begin
                    if (diff)
                        byte_v = (32'(b5[0][k]) << 3) | (32'(b5[1][k] - b5[0][k]) & 32'd7);
                    else
                        byte_v = ((32'(base[0][k]) >> 4) << 4) | (32'(base[1][k]) >> 4);
                    c |= (byte_v & 32'hff) << (24 - 8 * k);
                end
                c |= (32'(tsel[0]) << 5) | (32'(tsel[1]) << 2) | (diff ? 32'd2 : 32'd0)
                   | 32'(flip);
                msb = '0;
                lsb = '0;
                for (p = 0; p < 16; p++) begin
                    if (sel[p] & 2) msb[p] = 1'b1;
                    if (sel[p] & 1) lsb[p] = 1'b1;
                end
                r.color_word = c;
                r.index_word = (msb << 16) | lsb;
            end
        end
        return r;
    endfunction

    // sink side: random hold-off, plus one long hold to fill the block up
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            o_blk.ready <= 1'b0;
        end else if (recv_hold_cycles > 0) begin
            o_blk.ready <= 1'b0;
            recv_hold_cycles <= recv_hold_cycles - 1;
        end else begin
            o_blk.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_blk want;
        if (i_rst_n && o_blk.valid && o_blk.ready) begin
            if (blk_expected.size() == 0) begin
                err_count++;
                if (err_count <= 10)
                    $display("unexpected block transfer: %h %h",
                             o_blk.color_word, o_blk.index_word);
            end else begin
                want = blk_expected.pop_front();
                blk_checked++;
                if (o_blk.color_word !== want.color_word ||
                    o_blk.index_word !== want.index_word) begin
                    err_count++;
                    if (err_count <= 10)
                        $display("block %0d mismatch: color exp %h got %h, index exp %h got %h",
                                 blk_checked, want.color_word, o_blk.color_word,
                                 want.index_word, o_blk.index_word);
                end
            end
        end
    end

    // hands one pixel over, predicting the block after every sixteenth
    task automatic send_pixel(input t_rgb px, input logic known, input logic [31:0] cw,
                              input logic [31:0] iw);
        t_blk b;
        while ($urandom_range(99) < send_idle_pct) begin
            i_pix.valid <= 1'b0;
            @(negedge i_clk);
        end
        i_pix.valid <= 1'b1;
        i_pix.red   <= px.red;
        i_pix.green <= px.green;
        i_pix.blue  <= px.blue;
        @(posedge i_clk);
        while (!i_pix.ready) @(posedge i_clk);
        block_pix[pix_slot] = px;
        pix_sent++;
        if (pix_slot == 15) begin
            b = encode_block();
            if (known && (b.color_word != cw || b.index_word != iw)) begin
                err_count++;
                if (err_count <= 10)
                    $display("predictor disagrees with table: %h %h", b.color_word,
                             b.index_word);
            end
            blk_expected.push_back(b);
        end
        pix_slot = (pix_slot + 1) % 16;
        // valid stays up here so the next transfer can follow back to back
        @(negedge i_clk);
    endtask

    task automatic add_block(input t_rgb a, input t_rgb b, input int kind);
        int p;
        for (p = 0; p < 16; p++) begin
            t_row r;
            r.known = 1'b0;
            case (kind)
                0: r.pix = a;
                1: r.pix = (p < 8) ? a : b;
                2: r.pix = ((p & 3) < 2) ? a : b;
                default: r.pix = t_rgb'($urandom);
            endcase
            pix_table.push_back(r);
        end
    endtask

    task automatic send_random_block();
        t_rgb c0, c1;
        int   p, sp, kind;
        t_rgb px;
        kind = $urandom_range(9);
        c0 = t_rgb'($urandom);
        c1 = t_rgb'($urandom);
        sp = $urandom_range(1, 60);
        for (p = 0; p < 16; p++) begin
            case (kind)
                0: px = c0;
                1, 2, 3: begin
                    // small spread around one color, differential mode mostly
                    px.red   = 8'(clamp8(int'(c0.red) + $urandom_range(2 * sp) - sp));
                    px.green = 8'(clamp8(int'(c0.green) + $urandom_range(2 * sp) - sp));
                    px.blue  = 8'(clamp8(int'(c0.blue) + $urandom_range(2 * sp) - sp));
                end
                4, 5: px = (((kind == 4) ? (p >> 3) : ((p & 3) >> 1)) != 0) ? c1 : c0;
                default: px = t_rgb'($urandom);
            endcase
            send_pixel(px, 1'b0, '0, '0);
        end
    endtask

    task automatic wait_drained();
        i_pix.valid <= 1'b0;
        @(negedge i_clk);
        while (blk_expected.size() != 0) @(negedge i_clk);
    endtask

    initial begin
        int i;
        t_row r;
        err_count = 0;
        blk_checked = 0;
        pix_sent = 0;
        pix_slot = 0;
        recv_hold_cycles = 0;
        send_idle_pct = 32;
        recv_idle_pct = 47;
        i_rst_n = 1'b0;
        i_pix.valid = 1'b0;
        i_pix.red = '0;
        i_pix.green = '0;
        i_pix.blue = '0;
        o_blk.ready = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: uniform extremes with readable results, then split blocks and one random block
        r.known = 1'b1;
        r.pix = '{8'd0, 8'd0, 8'd0};
        for (i = 0; i < 16; i++) begin
            r.color_word = (i == 15) ? 32'h0000_0002 : '0;
            r.index_word = '0;
            r.known = (i == 15);
            pix_table.push_back(r);
        end
        r.pix = '{8'd255, 8'd255, 8'd255};
        for (i = 0; i < 16; i++) begin
            r.color_word = (i == 15) ? 32'hF8F8_F802 : '0;
            r.index_word = '0;
            r.known = (i == 15);
            pix_table.push_back(r);
        end
        add_block('{8'd0, 8'd0, 8'd0}, '{8'd255, 8'd255, 8'd255}, 1);
        add_block('{8'd255, 8'd0, 8'd170}, '{8'd0, 8'd255, 8'd85}, 2);
        add_block('{8'd100, 8'd100, 8'd100}, '{8'd104, 8'd98, 8'd100}, 1);
        add_block('0, '0, 3);
        foreach (pix_table[j])
            send_pixel(pix_table[j].pix, pix_table[j].known, pix_table[j].color_word,
                       pix_table[j].index_word);

        for (i = 0; i < 8; i++) send_random_block();
        send_idle_pct = 47;
        recv_idle_pct = 32;
        for (i = 0; i < 8; i++) send_random_block();
        // sender pauses until every block is out
        wait_drained();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        recv_hold_cycles = 2000;
        for (i = 0; i < 4; i++) send_random_block();
        for (i = 0; i < 4; i++) send_random_block();
        // leave a partial block behind: no result expected for it
        for (i = 0; i < 5; i++) send_pixel(t_rgb'($urandom), 1'b0, '0, '0);

        wait_drained();
        repeat (500) @(negedge i_clk);
        $display("sent %0d pixels, checked %0d encoded blocks (uniform, split, noisy, random)",
                 pix_sent, blk_checked);
        if (err_count == 0 && blk_expected.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire

/* filelist.f */
hw/rtl/etc1_pkg.sv
hw/rtl/etc1_ifs.sv
hw/rtl/etc1_err_unit.sv
hw/rtl/etc1_block_encoder_top.sv
tb/tb_etc1_block_encoder_top.sv
